### src/ecam_pkg.sv
// shared types, constants and tables for the euler fly camera block
// no dependencies; imported by the controller, the datapath and the top level

package ecam_pkg;

    localparam int VEC_FRAC     = 14;   // vector fraction bits, q1.14
    localparam int CORDIC_STEPS = 16;   // rotations per sine/cosine run, at most 32

    localparam int HALF_TURN   = 11520;
    localparam int FULL_TURN   = 23040;
    localparam int PITCH_LIMIT = 5696;
    localparam int QUARTER     = HALF_TURN / 2;
    localparam int CORDIC_ONE  = 16777216;
    localparam int SQRT_STEPS  = 32;

    localparam int IN_DATA_W  = 176;
    localparam int OUT_DATA_W = 240;

    // item kinds
    localparam logic [1:0] CMD_MOVE = 2'd0;
    localparam logic [1:0] CMD_LOOK = 2'd1;
    localparam logic [1:0] CMD_SET  = 2'd2;
    localparam logic [1:0] CMD_NONE = 2'd3;

    // move directions
    localparam logic [1:0] DIR_FWD   = 2'd0;
    localparam logic [1:0] DIR_BACK  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    // configuration register indexes
    localparam logic [2:0] REG_SPEED = 3'd0;
    localparam logic [2:0] REG_SENS  = 3'd1;
    localparam logic [2:0] REG_WUP_X = 3'd2;
    localparam logic [2:0] REG_WUP_Y = 3'd3;
    localparam logic [2:0] REG_WUP_Z = 3'd4;

    typedef enum logic [4:0] {
        ST_IDLE, ST_MOVE, ST_ANG, ST_WRAP, ST_WSAVE, ST_CINIT, ST_CSTEP, ST_CSAVE,
        ST_GSQ, ST_SQINIT, ST_SQSTEP, ST_SQSAVE, ST_RAW, ST_SUMSQ, ST_DINIT,
        ST_DSTEP, ST_DSAVE, ST_COMMIT, ST_CROSS, ST_DONE
    } state_t;

    typedef enum logic [4:0] {
        OP_IDLE, OP_LOAD, OP_MOVE, OP_ANG, OP_WRAP, OP_WSAVE, OP_CINIT, OP_CSTEP,
        OP_CSAVE, OP_GSQ, OP_SQINIT, OP_SQSTEP, OP_SQSAVE, OP_RAW, OP_SUMSQ,
        OP_DINIT, OP_DSTEP, OP_DSAVE, OP_COMMIT, OP_CROSS, OP_OUT
    } dp_op_t;

    typedef enum logic [1:0] {
        VS_FRONT, VS_RIGHT, VS_UP, VS_GAIN
    } vsel_t;

    typedef struct packed {
        dp_op_t      op;
        logic [4:0]  idx;
        logic [1:0]  k;
        vsel_t       vsel;
    } dp_cmd_t;

    typedef struct packed {
        logic        in_valid;
        logic [1:0]  in_cmd;
        logic        out_ready;
    } ctrl_stat_t;

    // arctangent of 2^-i in units of 2^-22 degree
    function automatic logic signed [31:0] atan_val(input logic [4:0] i);
        logic signed [31:0] r;
        case (i)
            5'd0:  r = 32'sd188743680;
            5'd1:  r = 32'sd111421900;
            5'd2:  r = 32'sd58872272;
            5'd3:  r = 32'sd29884485;
            5'd4:  r = 32'sd15000234;
            5'd5:  r = 32'sd7507429;
            5'd6:  r = 32'sd3754631;
            5'd7:  r = 32'sd1877430;
            5'd8:  r = 32'sd938729;
            5'd9:  r = 32'sd469366;
            5'd10: r = 32'sd234683;
            5'd11: r = 32'sd117342;
            5'd12: r = 32'sd58671;
            5'd13: r = 32'sd29335;
            5'd14: r = 32'sd14668;
            5'd15: r = 32'sd7334;
            5'd16: r = 32'sd3667;
            5'd17: r = 32'sd1833;
            5'd18: r = 32'sd917;
            5'd19: r = 32'sd458;
            5'd20: r = 32'sd229;
            5'd21: r = 32'sd115;
            5'd22: r = 32'sd57;
            5'd23: r = 32'sd29;
            5'd24: r = 32'sd14;
            5'd25: r = 32'sd7;
            5'd26: r = 32'sd4;
            5'd27: r = 32'sd2;
            5'd28: r = 32'sd1;
            default: r = 32'sd0;
        endcase
        return r;
    endfunction

endpackage

### src/ecam_ctrl.sv
// sequencer for the fly camera: walks each item through the datapath steps
// depends on ecam_pkg

module ecam_ctrl
    import ecam_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  ctrl_stat_t stat,
    output logic       in_ready,
    output logic       out_valid,
    output dp_cmd_t    cmd
);

    state_t     state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [1:0] k_reg, k_next;
    vsel_t      vsel_reg, vsel_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            k_reg         <= '0;
            vsel_reg      <= VS_FRONT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            k_reg         <= k_next;
            vsel_reg      <= vsel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || stat.out_ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (stat.out_ready)
            out_valid_next = 1'b0;
    end

    // next state and step counters
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        k_next     = k_reg;
        vsel_next  = vsel_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                k_next = '0;
                if (stat.in_valid)
                begin
                    unique case (stat.in_cmd)
                        CMD_MOVE:          state_next = ST_MOVE;
                        CMD_LOOK, CMD_SET: state_next = ST_ANG;
                        default:           state_next = ST_DONE;
                    endcase
                end
            end
            ST_MOVE:
            begin
                if (k_reg == 2'd2)
                    state_next = ST_DONE;
                k_next = k_reg + 2'd1;
            end
            ST_ANG:
            begin
                state_next = ST_WRAP;
                cnt_next   = 5'd7;
            end
            ST_WRAP:
            begin
                if (cnt_reg == '0)
                    state_next = ST_WSAVE;
                cnt_next = cnt_reg - 5'd1;
            end
            ST_WSAVE:
            begin
                if (k_reg == 2'd0)
                begin
                    state_next = ST_ANG;
                    k_next     = 2'd1;
                end
                else
                begin
                    state_next = ST_CINIT;
                    k_next     = 2'd0;
                end
            end
            ST_CINIT:
            begin
                state_next = ST_CSTEP;
                cnt_next   = '0;
            end
            ST_CSTEP:
            begin
                if (cnt_reg == 5'(CORDIC_STEPS - 1))
                    state_next = ST_CSAVE;
                cnt_next = cnt_reg + 5'd1;
            end
            ST_CSAVE:
            begin
                if (k_reg == 2'd0)
                begin
                    state_next = ST_CINIT;
                    k_next     = 2'd1;
                end
                else
                begin
                    state_next = ST_GSQ;
                    k_next     = 2'd0;
                    vsel_next  = VS_GAIN;
                end
            end
            ST_GSQ:
            begin
                if (k_reg == 2'd1)
                    state_next = ST_SQINIT;
                k_next = k_reg + 2'd1;
            end
            ST_SQINIT:
            begin
                state_next = ST_SQSTEP;
                cnt_next   = '0;
            end
            ST_SQSTEP:
            begin
                if (cnt_reg == 5'(SQRT_STEPS - 1))
                    state_next = ST_SQSAVE;
                cnt_next = cnt_reg + 5'd1;
            end
            ST_SQSAVE:
            begin
                k_next = '0;
                if (vsel_reg == VS_GAIN)
                begin
                    state_next = ST_RAW;
                    vsel_next  = VS_FRONT;
                end
                else
                    state_next = ST_DINIT;
            end
            ST_RAW:
            begin
                if (k_reg == 2'd2)
                begin
                    state_next = ST_SUMSQ;
                    k_next     = '0;
                end
                else
                    k_next = k_reg + 2'd1;
            end
            ST_SUMSQ:
            begin
                if (k_reg == 2'd2)
                    state_next = ST_SQINIT;
                k_next = k_reg + 2'd1;
            end
            ST_DINIT:
            begin
                state_next = ST_DSTEP;
                cnt_next   = 5'(VEC_FRAC);
            end
            ST_DSTEP:
            begin
                if (cnt_reg == '0)
                    state_next = ST_DSAVE;
                cnt_next = cnt_reg - 5'd1;
            end
            ST_DSAVE:
            begin
                if (k_reg == 2'd2)
                    state_next = ST_COMMIT;
                else
                begin
                    state_next = ST_DINIT;
                    k_next     = k_reg + 2'd1;
                end
            end
            ST_COMMIT:
            begin
                k_next   = '0;
                cnt_next = '0;
                unique case (vsel_reg)
                    VS_FRONT:
                    begin
                        state_next = ST_CROSS;
                        vsel_next  = VS_RIGHT;
                    end
                    VS_RIGHT:
                    begin
                        state_next = ST_CROSS;
                        vsel_next  = VS_UP;
                    end
                    default:
                        state_next = ST_DONE;
                endcase
            end
            ST_CROSS:
            begin
                if (cnt_reg[0])
                begin
                    cnt_next = '0;
                    if (k_reg == 2'd2)
                    begin
                        state_next = ST_SUMSQ;
                        k_next     = '0;
                    end
                    else
                        k_next = k_reg + 2'd1;
                end
                else
                    cnt_next = 5'd1;
            end
            ST_DONE:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath command for the current step
    always_comb
    begin
        cmd.idx  = cnt_reg;
        cmd.k    = k_reg;
        cmd.vsel = vsel_reg;
        cmd.op   = OP_IDLE;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (stat.in_valid)
                    cmd.op = OP_LOAD;
            end
            ST_MOVE:   cmd.op = OP_MOVE;
            ST_ANG:    cmd.op = OP_ANG;
            ST_WRAP:   cmd.op = OP_WRAP;
            ST_WSAVE:  cmd.op = OP_WSAVE;
            ST_CINIT:  cmd.op = OP_CINIT;
            ST_CSTEP:  cmd.op = OP_CSTEP;
            ST_CSAVE:  cmd.op = OP_CSAVE;
            ST_GSQ:    cmd.op = OP_GSQ;
            ST_SQINIT: cmd.op = OP_SQINIT;
            ST_SQSTEP: cmd.op = OP_SQSTEP;
            ST_SQSAVE: cmd.op = OP_SQSAVE;
            ST_RAW:    cmd.op = OP_RAW;
            ST_SUMSQ:  cmd.op = OP_SUMSQ;
            ST_DINIT:  cmd.op = OP_DINIT;
            ST_DSTEP:  cmd.op = OP_DSTEP;
            ST_DSAVE:  cmd.op = OP_DSAVE;
            ST_COMMIT: cmd.op = OP_COMMIT;
            ST_CROSS:  cmd.op = OP_CROSS;
            ST_DONE:   cmd.op = out_load ? OP_OUT : OP_IDLE;
            default:   cmd.op = OP_IDLE;
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

### src/ecam_dp.sv
// datapath of the fly camera: pose state, shared multiplier, cordic, square root,
// divider and angle wrap units, output register; depends on ecam_pkg

module ecam_dp
    import ecam_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  dp_cmd_t                 cmd,
    input  logic                    cfg_we,
    input  logic [2:0]              cfg_addr,
    input  logic [15:0]             cfg_data,
    input  logic [1:0]              in_cmd,
    input  logic [1:0]              in_direction,
    input  logic [15:0]             in_delta_time,
    input  logic signed [15:0]      in_x_offset,
    input  logic signed [15:0]      in_y_offset,
    input  logic                    in_constrain_pitch,
    input  logic signed [31:0]      in_set_pos_x,
    input  logic signed [31:0]      in_set_pos_y,
    input  logic signed [31:0]      in_set_pos_z,
    input  logic signed [14:0]      in_set_yaw,
    input  logic signed [13:0]      in_set_pitch,
    output logic [OUT_DATA_W-1:0]   out_data
);

    localparam logic [23:0] WRAP_BIAS = 24'(FULL_TURN * 128);

    // configuration
    logic [15:0]        speed_reg, sens_reg;
    logic signed [15:0] wu_reg [3];

    // latched item
    logic [1:0]         cmd_reg, dir_reg;
    logic signed [15:0] xo_reg, yo_reg;
    logic               cons_reg;
    logic signed [14:0] syaw_reg;
    logic signed [13:0] spit_reg;
    logic [31:0]        vel_reg;

    // pose
    logic signed [31:0] pos_reg [3];
    logic signed [15:0] yaw_reg, pitch_reg;
    logic signed [15:0] fv_reg [3];
    logic signed [15:0] rv_reg [3];
    logic signed [15:0] uv_reg [3];

    // work registers
    logic [23:0]        wv_reg;
    logic               clamp_reg;
    logic signed [27:0] cx_reg, cy_reg;
    logic signed [31:0] cz_reg;
    logic               cneg_reg;
    logic signed [27:0] ycos_reg, ysin_reg, pcos_reg, psin_reg;
    logic [27:0]        g_reg;
    logic signed [31:0] vec_reg [3];
    logic [63:0]        sum_reg, sv_reg, res_reg;
    logic [31:0]        len_reg;
    logic [46:0]        rem_reg;
    logic [VEC_FRAC:0]  q_reg;
    logic               dneg_reg;
    logic signed [15:0] nv_reg [3];
    logic [OUT_DATA_W-1:0] out_reg;

    // shared multiplier
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;

    logic signed [15:0] mvec, ca1, ca2, cb1, cb2;
    logic               msub;
    logic [1:0]         i1, i2;
    logic signed [65:0] mv_sh, ang_sh, raw_sh;
    logic signed [33:0] mv_sum;
    logic signed [31:0] mv_sat;
    logic signed [24:0] ang_base, ang_sum, ang_clamp, ang_bias;
    logic [23:0]        wcmp;
    logic signed [15:0] cang, cfold;
    logic               cflip;
    logic signed [27:0] cxs, cys;
    logic signed [31:0] catan;
    logic [63:0]        sq_one, sq_trial;
    logic [46:0]        dv;
    logic [31:0]        dam;

    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        unique case (cmd.k)
            2'd0:    begin i1 = 2'd1; i2 = 2'd2; end
            2'd1:    begin i1 = 2'd2; i2 = 2'd0; end
            default: begin i1 = 2'd0; i2 = 2'd1; end
        endcase
        if (cmd.vsel == VS_RIGHT)
        begin
            ca1 = fv_reg[i1]; ca2 = fv_reg[i2];
            cb1 = wu_reg[i1]; cb2 = wu_reg[i2];
        end
        else
        begin
            ca1 = rv_reg[i1]; ca2 = rv_reg[i2];
            cb1 = fv_reg[i1]; cb2 = fv_reg[i2];
        end
        mvec = (dir_reg == DIR_FWD || dir_reg == DIR_BACK) ? fv_reg[cmd.k] : rv_reg[cmd.k];
        msub = (dir_reg == DIR_BACK || dir_reg == DIR_LEFT);
    end

    // multiplier operand selection
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            OP_MOVE:
            begin
                mul_a = 33'(mvec);
                mul_b = $signed({1'b0, vel_reg});
            end
            OP_ANG:
            begin
                mul_a = (cmd.k == 2'd0) ? 33'(xo_reg) : 33'(yo_reg);
                mul_b = $signed({17'b0, sens_reg});
            end
            OP_GSQ:
            begin
                mul_a = (cmd.k == 2'd0) ? 33'(ycos_reg) : 33'(ysin_reg);
                mul_b = mul_a;
            end
            OP_RAW:
            begin
                unique case (cmd.k)
                    2'd0:    begin mul_a = 33'(ycos_reg); mul_b = 33'(pcos_reg); end
                    2'd1:    begin mul_a = 33'(psin_reg); mul_b = $signed({5'b0, g_reg}); end
                    default: begin mul_a = 33'(ysin_reg); mul_b = 33'(pcos_reg); end
                endcase
            end
            OP_CROSS:
            begin
                mul_a = cmd.idx[0] ? 33'(ca2) : 33'(ca1);
                mul_b = cmd.idx[0] ? 33'(cb1) : 33'(cb2);
            end
            OP_SUMSQ:
            begin
                mul_a = 33'(vec_reg[cmd.k]);
                mul_b = mul_a;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        // move: round half up into q16.16, then saturate
        mv_sh  = (mul_p + (66'sd1 <<< (VEC_FRAC + 7))) >>> (VEC_FRAC + 8);
        mv_sum = msub ? 34'(pos_reg[cmd.k]) - mv_sh[33:0] : 34'(pos_reg[cmd.k]) + mv_sh[33:0];
        if (mv_sum > 34'sh07fffffff)
            mv_sat = 32'sh7fffffff;
        else if (mv_sum < -34'sh080000000)
            mv_sat = 32'sh80000000;
        else
            mv_sat = mv_sum[31:0];

        // angle update
        ang_sh = (mul_p + 66'sd512) >>> 10;
        if (cmd_reg == CMD_LOOK)
        begin
            ang_base = (cmd.k == 2'd0) ? 25'(yaw_reg) : 25'(pitch_reg);
            ang_sum  = ang_base + ang_sh[24:0];
        end
        else
        begin
            ang_base = (cmd.k == 2'd0) ? 25'(syaw_reg) : 25'(spit_reg);
            ang_sum  = ang_base;
        end
        if (ang_sum > 25'sd5696)
            ang_clamp = 25'(PITCH_LIMIT);
        else if (ang_sum < -25'sd5696)
            ang_clamp = -25'(PITCH_LIMIT);
        else
            ang_clamp = ang_sum;
        ang_bias = ang_sum + 25'(HALF_TURN);
        wcmp     = 24'(FULL_TURN) << cmd.idx[2:0];

        // cordic fold into +/- 90 degrees
        cang = (cmd.k == 2'd0) ? yaw_reg : pitch_reg;
        if (cang > 16'sd5760)
        begin
            cfold = cang - 16'(HALF_TURN);
            cflip = 1'b1;
        end
        else if (cang < -16'sd5760)
        begin
            cfold = cang + 16'(HALF_TURN);
            cflip = 1'b1;
        end
        else
        begin
            cfold = cang;
            cflip = 1'b0;
        end
        cxs   = cx_reg >>> cmd.idx;
        cys   = cy_reg >>> cmd.idx;
        catan = atan_val(cmd.idx);

        raw_sh = mul_p >>> 20;

        // square root and divide steps
        sq_one   = 64'd1 << (6'd62 - {cmd.idx, 1'b0});
        sq_trial = res_reg + sq_one;
        dv       = 47'(len_reg) << cmd.idx[3:0];
        dam      = vec_reg[cmd.k][31] ? 32'(-vec_reg[cmd.k]) : 32'(vec_reg[cmd.k]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg <= 16'd640;
            sens_reg  <= 16'd6554;
            wu_reg[0] <= '0;
            wu_reg[1] <= 16'sd16384;
            wu_reg[2] <= '0;
            for (int i = 0; i < 3; i++)
                pos_reg[i] <= '0;
            fv_reg[0] <= '0;
            fv_reg[1] <= -(16'sd1 <<< VEC_FRAC);
            fv_reg[2] <= '0;
            rv_reg[0] <= 16'sd1 <<< VEC_FRAC;
            rv_reg[1] <= '0;
            rv_reg[2] <= '0;
            uv_reg[0] <= '0;
            uv_reg[1] <= 16'sd1 <<< VEC_FRAC;
            uv_reg[2] <= '0;
            yaw_reg   <= '0;
            pitch_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_SPEED: speed_reg <= cfg_data;
                    REG_SENS:  sens_reg  <= cfg_data;
                    REG_WUP_X: wu_reg[0] <= cfg_data;
                    REG_WUP_Y: wu_reg[1] <= cfg_data;
                    REG_WUP_Z: wu_reg[2] <= cfg_data;
                    default:   ;
                endcase
            end
            unique case (cmd.op)
                OP_MOVE:
                    pos_reg[cmd.k] <= mv_sat;
                OP_ANG:
                begin
                    if (cmd.k == 2'd1 && cmd_reg == CMD_LOOK && cons_reg)
                        pitch_reg <= ang_clamp[15:0];
                end
                OP_WSAVE:
                begin
                    if (!clamp_reg)
                    begin
                        if (cmd.k == 2'd0)
                            yaw_reg <= 16'(wv_reg) - 16'(HALF_TURN);
                        else
                            pitch_reg <= 16'(wv_reg) - 16'(HALF_TURN);
                    end
                end
                OP_LOAD:
                begin
                    if (in_cmd == CMD_SET)
                    begin
                        pos_reg[0] <= in_set_pos_x;
                        pos_reg[1] <= in_set_pos_y;
                        pos_reg[2] <= in_set_pos_z;
                    end
                end
                OP_COMMIT:
                begin
                    if (sum_reg != '0)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            unique case (cmd.vsel)
                                VS_FRONT: fv_reg[i] <= nv_reg[i];
                                VS_RIGHT: rv_reg[i] <= nv_reg[i];
                                default:  uv_reg[i] <= nv_reg[i];
                            endcase
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // work registers, no reset needed
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                cmd_reg     <= in_cmd;
                dir_reg     <= in_direction;
                xo_reg      <= in_x_offset;
                yo_reg      <= in_y_offset;
                cons_reg    <= in_constrain_pitch;
                syaw_reg    <= in_set_yaw;
                spit_reg    <= in_set_pitch;
                vel_reg     <= 32'(speed_reg) * 32'(in_delta_time);
            end
            OP_ANG:
            begin
                clamp_reg <= (cmd.k == 2'd1 && cmd_reg == CMD_LOOK && cons_reg);
                wv_reg    <= ang_bias[24] ? 24'(ang_bias) + WRAP_BIAS : 24'(ang_bias);
            end
            OP_WRAP:
            begin
                if (wv_reg >= wcmp)
                    wv_reg <= wv_reg - wcmp;
            end
            OP_CINIT:
            begin
                cx_reg   <= 28'sd16777216;
                cy_reg   <= '0;
                cz_reg   <= {cfold, 16'h0000};
                cneg_reg <= cflip;
            end
            OP_CSTEP:
            begin
                if (!cz_reg[31])
                begin
                    cx_reg <= cx_reg - cys;
                    cy_reg <= cy_reg + cxs;
                    cz_reg <= cz_reg - catan;
                end
                else
                begin
                    cx_reg <= cx_reg + cys;
                    cy_reg <= cy_reg - cxs;
                    cz_reg <= cz_reg + catan;
                end
            end
            OP_CSAVE:
            begin
                if (cmd.k == 2'd0)
                begin
                    ycos_reg <= cneg_reg ? -cx_reg : cx_reg;
                    ysin_reg <= cneg_reg ? -cy_reg : cy_reg;
                end
                else
                begin
                    pcos_reg <= cneg_reg ? -cx_reg : cx_reg;
                    psin_reg <= cneg_reg ? -cy_reg : cy_reg;
                end
            end
            OP_GSQ:
                sum_reg <= (cmd.k == 2'd0) ? mul_p[63:0] : sum_reg + mul_p[63:0];
            OP_SUMSQ:
                sum_reg <= (cmd.k == 2'd0) ? mul_p[63:0] : sum_reg + mul_p[63:0];
            OP_SQINIT:
            begin
                sv_reg  <= sum_reg;
                res_reg <= '0;
            end
            OP_SQSTEP:
            begin
                if (sv_reg >= sq_trial)
                begin
                    sv_reg  <= sv_reg - sq_trial;
                    res_reg <= (res_reg >> 1) + sq_one;
                end
                else
                    res_reg <= res_reg >> 1;
            end
            OP_SQSAVE:
            begin
                if (cmd.vsel == VS_GAIN)
                    g_reg <= res_reg[27:0];
                else
                    len_reg <= res_reg[31:0];
            end
            OP_RAW:
                vec_reg[cmd.k] <= raw_sh[31:0];
            OP_CROSS:
            begin
                if (cmd.idx[0])
                    vec_reg[cmd.k] <= vec_reg[cmd.k] - mul_p[31:0];
                else
                    vec_reg[cmd.k] <= mul_p[31:0];
            end
            OP_DINIT:
            begin
                rem_reg  <= (47'(dam) << VEC_FRAC) + 47'(len_reg >> 1);
                q_reg    <= '0;
                dneg_reg <= vec_reg[cmd.k][31];
            end
            OP_DSTEP:
            begin
                if (rem_reg >= dv)
                begin
                    rem_reg            <= rem_reg - dv;
                    q_reg[cmd.idx[3:0]] <= 1'b1;
                end
            end
            OP_DSAVE:
                nv_reg[cmd.k] <= dneg_reg ? -16'(q_reg) : 16'(q_reg);
            OP_OUT:
                out_reg <= {uv_reg[2], uv_reg[1], uv_reg[0],
                            rv_reg[2], rv_reg[1], rv_reg[0],
                            fv_reg[2], fv_reg[1], fv_reg[0],
                            pos_reg[2], pos_reg[1], pos_reg[0]};
            default: ;
        endcase
    end

    assign out_data = out_reg;

endmodule

### src/euler_fly_camera_update.sv
// top level of the euler-angle fly camera: stream ports, configuration port
// depends on ecam_pkg, ecam_ctrl and ecam_dp

// Keeps a camera pose (q16.16 position, yaw and pitch in 1/64 degree, q1.14
// front/right/up unit vectors) and returns the pose after every item on the
// master stream. cmd on s_tuser: 0 moves along +/-front or +/-right by
// speed * delta_time with saturation, 1 adds mouse offsets times sensitivity
// to the angles, 2 loads position and angles, 3 only reports. One item is in
// flight at a time; the finished pose waits in an output register so the next
// item can be taken while it is unread. A look or set item rebuilds the
// vectors through two angle wraps, two 16-step cordic runs, four 32-step
// square roots and nine 15-step divisions on a single shared unit each,
// plus one multiply per cycle for the products.
// Configuration writes are always accepted and must only happen while idle.

module euler_fly_camera_update
    import ecam_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // direction, delta_time, x_offset, y_offset, constrain_pitch,
    // set_pos_x, set_pos_y, set_pos_z, set_yaw, set_pitch
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // cmd
    input  logic [1:0]            s_tuser,
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // pos_x, pos_y, pos_z, front_x/y/z, right_x/y/z, up_x/y/z
    output logic [OUT_DATA_W-1:0] m_tdata,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [2:0]            cfg_addr,
    input  logic [15:0]           cfg_data
);

    ctrl_stat_t stat;
    dp_cmd_t    cmd;

    // registers are simple flops, so a write transfer completes at once
    assign cfg_ready = 1'b1;

    assign stat.in_valid  = s_tvalid;
    assign stat.in_cmd    = s_tuser;
    assign stat.out_ready = m_tready;

    // sequencer: one state per datapath step
    ecam_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .stat      (stat),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .cmd       (cmd)
    );

    // datapath: pose registers and the iterative arithmetic units
    ecam_dp u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .cfg_we             (cfg_valid),
        .cfg_addr           (cfg_addr),
        .cfg_data           (cfg_data),
        .in_cmd             (s_tuser),
        .in_direction       (s_tdata[1:0]),
        .in_delta_time      (s_tdata[17:2]),
        .in_x_offset        (s_tdata[33:18]),
        .in_y_offset        (s_tdata[49:34]),
        .in_constrain_pitch (s_tdata[50]),
        .in_set_pos_x       (s_tdata[82:51]),
        .in_set_pos_y       (s_tdata[114:83]),
        .in_set_pos_z       (s_tdata[146:115]),
        .in_set_yaw         (s_tdata[161:147]),
        .in_set_pitch       (s_tdata[175:162]),
        .out_data           (m_tdata)
    );

endmodule

### tb/sv/euler_fly_camera_update_tb.sv
// self-checking testbench for the euler fly camera block: directed table, then random phases
// depends on ecam_pkg and euler_fly_camera_update; the pose predictor lives in this file

module euler_fly_camera_update_tb;
    import ecam_pkg::*;

    typedef longint vec3_t [3];

    typedef struct {
        logic [1:0]         cmd;
        logic [1:0]         dir;
        logic [15:0]        dt;
        logic signed [15:0] xo;
        logic signed [15:0] yo;
        logic               clamp;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [14:0] syaw;
        logic signed [13:0] spitch;
        bit                 has_pose;   // pose typed in by hand
        logic [OUT_DATA_W-1:0] pose;
    } cam_item_t;

    // arctangent of 2^-i in units of 2^-22 degree
    localparam longint ATAN_TAB [32] = '{
        188743680, 111421900, 58872272, 29884485, 15000234, 7507429, 3754631,
        1877430, 938729, 469366, 234683, 117342, 58671, 29335, 14668, 7334,
        3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0, 0, 0
    };

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [1:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [2:0]            cfg_addr;
    logic [15:0]           cfg_data;

    euler_fly_camera_update dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    // predicted camera state and register copies
    logic [15:0] speed_q88, sens_q016, wup_x, wup_y, wup_z;
    longint      cam_pos [3];
    longint      cam_yaw, cam_pitch;
    vec3_t       cam_front, cam_right, cam_up;

    logic [OUT_DATA_W-1:0] pose_q [$];
    cam_item_t             dir_tab [$];
    int  mismatches = 0;
    int  poses_seen = 0;
    int  items_sent = 0;
    int  tx_idle_pct = 0;
    int  rx_stall_pct = 0;
    bit  hold_request = 0;
    int  hold_left = 0;

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic longint unsigned isqrt_u64(longint unsigned v);
        longint unsigned res, one;
        res = 0;
        one = 64'd1 << 62;
        while (one > v)
            one >>= 2;
        while (one != 0)
        begin
            if (v >= res + one)
            begin
                v   = v - (res + one);
                res = (res >> 1) + one;
            end
            else
                res = res >> 1;
            one >>= 2;
        end
        return res;
    endfunction

    function automatic longint wrap_turn(longint v);
        longint r;
        r = (v + HALF_TURN) % FULL_TURN;
        if (r < 0)
            r += FULL_TURN;
        return r - HALF_TURN;
    endfunction

    // sine and cosine of an angle in 1/64 degree, folded into +/-90 degrees first
    task automatic sin_cos(input longint ang, output longint c, output longint s);
        longint x, y, z, nx;
        bit     flip;
        x = CORDIC_ONE;
        y = 0;
        flip = 0;
        if (ang > QUARTER)
        begin
            ang -= HALF_TURN;
            flip = 1;
        end
        else if (ang < -QUARTER)
        begin
            ang += HALF_TURN;
            flip = 1;
        end
        z = ang * 65536;
        for (int i = 0; i < CORDIC_STEPS && i < 32; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  -= ATAN_TAB[i];
            end
            else
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  += ATAN_TAB[i];
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    // scale to unit length in q1.14; fails on a zero vector
    task automatic unit_vec(input vec3_t v, output bit ok, output vec3_t o);
        vec3_t           a;
        longint          m, mag;
        longint unsigned sum, len, am, q;
        int              sh;
        m = 0;
        sum = 0;
        sh = 0;
        ok = 0;
        o = v;
        for (int k = 0; k < 3; k++)
        begin
            mag = v[k] < 0 ? -v[k] : v[k];
            if (mag > m)
                m = mag;
        end
        if (m == 0)
            return;
        while ((m >>> sh) >= 64'sd2147483648)
            sh++;
        for (int k = 0; k < 3; k++)
        begin
            a[k] = v[k] >>> sh;
            sum += longint'(a[k] * a[k]);
        end
        len = isqrt_u64(sum);
        if (len == 0)
            return;
        for (int k = 0; k < 3; k++)
        begin
            am = a[k] < 0 ? -a[k] : a[k];
            q  = ((am << VEC_FRAC) + len / 2) / len;
            o[k] = a[k] < 0 ? -longint'(q) : longint'(q);
        end
        ok = 1;
    endtask

    function automatic vec3_t cross3(vec3_t a, vec3_t b);
        vec3_t r;
        r[0] = a[1] * b[2] - a[2] * b[1];
        r[1] = a[2] * b[0] - a[0] * b[2];
        r[2] = a[0] * b[1] - a[1] * b[0];
        return r;
    endfunction

    // rebuild front/right/up from yaw and pitch; degenerate vectors keep the old value
    task automatic rebuild_basis();
        longint cy, sy, cp, sp, g;
        vec3_t  raw, nv, wu;
        bit     ok;
        sin_cos(cam_yaw, cy, sy);
        sin_cos(cam_pitch, cp, sp);
        g = longint'(isqrt_u64(longint'(cy * cy + sy * sy)));
        raw[0] = (cy * cp) >>> 20;
        raw[1] = (sp * g) >>> 20;
        raw[2] = (sy * cp) >>> 20;
        unit_vec(raw, ok, nv);
        if (ok)
            cam_front = nv;
        wu[0] = longint'($signed(wup_x));
        wu[1] = longint'($signed(wup_y));
        wu[2] = longint'($signed(wup_z));
        unit_vec(cross3(cam_front, wu), ok, nv);
        if (ok)
            cam_right = nv;
        unit_vec(cross3(cam_right, cam_front), ok, nv);
        if (ok)
            cam_up = nv;
    endtask

    // apply one item to the predicted state and return the reported pose
    task automatic step_pose(input cam_item_t it, output logic [OUT_DATA_W-1:0] pose);
        longint vel, d, p, dyaw, dpitch, sens;
        vec3_t  vec;
        bit     sub;
        case (it.cmd)
            CMD_MOVE:
            begin
                vel = longint'(speed_q88) * longint'(it.dt);
                vec = (it.dir == DIR_FWD || it.dir == DIR_BACK) ? cam_front : cam_right;
                sub = (it.dir == DIR_BACK || it.dir == DIR_LEFT);
                for (int k = 0; k < 3; k++)
                begin
                    d = (vec[k] * vel + (64'sd1 << (VEC_FRAC + 7))) >>> (VEC_FRAC + 8);
                    p = sub ? cam_pos[k] - d : cam_pos[k] + d;
                    if (p > 64'sd2147483647)
                        p = 64'sd2147483647;
                    if (p < -64'sd2147483648)
                        p = -64'sd2147483648;
                    cam_pos[k] = p;
                end
            end
            CMD_LOOK:
            begin
                sens   = longint'(sens_q016);
                dyaw   = (longint'(it.xo) * sens + 512) >>> 10;
                dpitch = (longint'(it.yo) * sens + 512) >>> 10;
                p = cam_pitch + dpitch;
                cam_yaw = wrap_turn(cam_yaw + dyaw);
                if (it.clamp)
                begin
                    if (p > PITCH_LIMIT)
                        p = PITCH_LIMIT;
                    if (p < -PITCH_LIMIT)
                        p = -PITCH_LIMIT;
                    cam_pitch = p;
                end
                else
                    cam_pitch = wrap_turn(p);
                rebuild_basis();
            end
            CMD_SET:
            begin
                cam_pos[0] = longint'(it.px);
                cam_pos[1] = longint'(it.py);
                cam_pos[2] = longint'(it.pz);
                cam_yaw    = wrap_turn(longint'(it.syaw));
                cam_pitch  = wrap_turn(longint'(it.spitch));
                rebuild_basis();
            end
            default: ;  // report only
        endcase
        pose = {cam_up[2][15:0], cam_up[1][15:0], cam_up[0][15:0],
                cam_right[2][15:0], cam_right[1][15:0], cam_right[0][15:0],
                cam_front[2][15:0], cam_front[1][15:0], cam_front[0][15:0],
                cam_pos[2][31:0], cam_pos[1][31:0], cam_pos[0][31:0]};
    endtask

    // ---------------------------------------------------------------- stimulus

    function automatic cam_item_t mk_item(logic [1:0] cmd, logic [1:0] dir, logic [15:0] dt,
                                          logic [15:0] xo, logic [15:0] yo, logic clamp,
                                          logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                          logic [14:0] syaw, logic [13:0] spitch);
        cam_item_t it;
        it.cmd = cmd;  it.dir = dir;  it.dt = dt;  it.xo = xo;  it.yo = yo;
        it.clamp = clamp;  it.px = px;  it.py = py;  it.pz = pz;
        it.syaw = syaw;  it.spitch = spitch;
        it.has_pose = 0;
        it.pose = '0;
        return it;
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'h7FFF_0000 + $urandom_range(0, 16'hFFFF);   // near the top, to saturate
            2: return 32'h8000_FFFF - $urandom_range(0, 16'hFFFF);   // near the bottom
            default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
        endcase
    endfunction

    function automatic cam_item_t rand_item();
        cam_item_t it;
        int        pick;
        pick = $urandom_range(0, 99);
        it = mk_item(pick < 45 ? CMD_MOVE : pick < 75 ? CMD_LOOK : pick < 92 ? CMD_SET : CMD_NONE,
                     $urandom_range(0, 3), $urandom, $urandom, $urandom, $urandom_range(0, 1),
                     rand_coord(), rand_coord(), rand_coord(), $urandom, $urandom);
        // keep mouse moves small most of the time so the angles walk around smoothly
        if ($urandom_range(0, 3) != 0)
        begin
            it.xo = $urandom_range(0, 400) - 200;
            it.yo = $urandom_range(0, 400) - 200;
        end
        return it;
    endfunction

    // offer one item, with random sender gaps, and queue its predicted pose on transfer
    task automatic send_item(cam_item_t it);
        logic [OUT_DATA_W-1:0] pose;
        bit ok;
        if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < tx_idle_pct)
                @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.cmd;
        s_tdata  <= {it.spitch, it.syaw, it.pz, it.py, it.px, it.clamp,
                     it.yo, it.xo, it.dt, it.dir};
        do
        begin
            @(negedge clk);
            ok = s_tready;
            @(posedge clk);
        end
        while (!ok);
        step_pose(it, pose);
        pose_q.push_back(it.has_pose ? it.pose : pose);
        items_sent++;
    endtask

    // writes go only while nothing is in flight
    task automatic write_regs(logic [15:0] spd, logic [15:0] sns,
                              logic [15:0] ux, logic [15:0] uy, logic [15:0] uz);
        logic [15:0] vals [5];
        logic [2:0]  idx  [5];
        bit          ok;
        vals = '{spd, sns, ux, uy, uz};
        idx  = '{REG_SPEED, REG_SENS, REG_WUP_X, REG_WUP_Y, REG_WUP_Z};
        for (int r = 0; r < 5; r++)
        begin
            cfg_valid <= 1'b1;
            cfg_addr  <= idx[r];
            cfg_data  <= vals[r];
            do
            begin
                @(negedge clk);
                ok = cfg_ready;
                @(posedge clk);
            end
            while (!ok);
        end
        cfg_valid <= 1'b0;
        speed_q88 = spd;  sens_q016 = sns;  wup_x = ux;  wup_y = uy;  wup_z = uz;
    endtask

    task automatic drain_poses();
        s_tvalid <= 1'b0;
        while (pose_q.size() != 0)
            @(posedge clk);
        // every item answers, but let the pipeline settle anyway
        repeat (400) @(posedge clk);
    endtask

    // ---------------------------------------------------------------- result side

    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_request = 0;
            hold_left = 600;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= !(rx_stall_pct > 0 && $urandom_range(0, 99) < rx_stall_pct);
    end

    // handshake values are stable at the falling edge and hold through the next rising edge
    always @(negedge clk)
    begin
        logic [OUT_DATA_W-1:0] want;
        bit bad;
        if (rst_n && m_tvalid && m_tready)
        begin
            poses_seen++;
            if (pose_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pose transfer: %h", m_tdata);
            end
            else
            begin
                want = pose_q.pop_front();
                bad = 0;
                for (int f = 0; f < 12; f++)
                begin
                    logic [31:0] got_f, exp_f;
                    if (f < 3)
                    begin
                        got_f = m_tdata[f*32 +: 32];
                        exp_f = want[f*32 +: 32];
                    end
                    else
                    begin
                        got_f = m_tdata[96 + (f-3)*16 +: 16];
                        exp_f = want[96 + (f-3)*16 +: 16];
                    end
                    if (got_f !== exp_f)
                    begin
                        bad = 1;
                        if (mismatches < 10)
                            $display("pose %0d field %0d: expected %h got %h",
                                     poses_seen, f, exp_f, got_f);
                    end
                end
                if (bad)
                    mismatches++;
            end
        end
    end

    // ---------------------------------------------------------------- main sequence

    initial
    begin
        cam_item_t it;
        int        phase_n;
        s_tvalid  = 0;
        s_tdata   = '0;
        s_tuser   = CMD_NONE;
        m_tready  = 0;
        cfg_valid = 0;
        cfg_addr  = REG_SPEED;
        cfg_data  = '0;
        rst_n     = 0;

        speed_q88 = 640;  sens_q016 = 6554;  wup_x = 0;  wup_y = 16384;  wup_z = 0;
        cam_pos = '{0, 0, 0};
        cam_yaw = 0;
        cam_pitch = 0;
        cam_front = '{0, -16384, 0};
        cam_right = '{16384, 0, 0};
        cam_up    = '{0, 16384, 0};

        // directed rows; only the report straight after reset is typed in
        it = mk_item(CMD_NONE, DIR_FWD, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        it.has_pose = 1;
        it.pose = {16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384,
                   16'sd0, -16'sd16384, 16'sd0, 32'sd0, 32'sd0, 32'sd0};
        dir_tab.push_back(it);
        dir_tab.push_back(mk_item(CMD_MOVE, DIR_FWD,   16'hFFFF, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk_item(CMD_MOVE, DIR_BACK,  16'h0000, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk_item(CMD_MOVE, DIR_LEFT,  16'hFFFF, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk_item(CMD_MOVE, DIR_RIGHT, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0, 0));
        // position and angle extremes, then out-of-range angles that wrap
        dir_tab.push_back(mk_item(CMD_SET, DIR_FWD, 0, 0, 0, 0,
                                  32'h7FFF_FFFF, 32'h8000_0000, 0, 11519, 5760));
        dir_tab.push_back(mk_item(CMD_SET, DIR_FWD, 0, 0, 0, 0,
                                  32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, -11520, -5760));
        dir_tab.push_back(mk_item(CMD_SET, DIR_FWD, 0, 0, 0, 1,
                                  32'h7FFF_0000, 0, 32'h8000_FFFF, 15'h4000, 14'h1FFF));
        // move beyond the position limits
        dir_tab.push_back(mk_item(CMD_MOVE, DIR_FWD,   16'hFFFF, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk_item(CMD_MOVE, DIR_LEFT,  16'hFFFF, 0, 0, 0, 0, 0, 0, 0, 0));
        // mouse extremes with and without the pitch clamp
        dir_tab.push_back(mk_item(CMD_LOOK, DIR_FWD, 0, 16'h7FFF, 16'h7FFF, 1, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk_item(CMD_LOOK, DIR_FWD, 0, 16'h8000, 16'h8000, 1, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk_item(CMD_LOOK, DIR_FWD, 0, 16'h7FFF, 16'h7FFF, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk_item(CMD_LOOK, DIR_FWD, 0, 16'h8000, 16'h8000, 0, 0, 0, 0, 0, 0));
        // straight up: front parallel to world up, right and up are kept
        dir_tab.push_back(mk_item(CMD_SET, DIR_FWD, 0, 0, 0, 0, 0, 0, 0, 0, 5760));
        dir_tab.push_back(mk_item(CMD_MOVE, DIR_RIGHT, 16'h8000, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk_item(CMD_SET, DIR_FWD, 0, 0, 0, 0, 0, 0, 0, 0, -5760));
        dir_tab.push_back(mk_item(CMD_LOOK, DIR_FWD, 0, 16'd1, -16'sd1, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk_item(CMD_NONE, DIR_RIGHT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1,
                                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 15'h7FFF, 14'h3FFF));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
            send_item(dir_tab[i]);
        drain_poses();

        // register extremes, zero world up, then random settings
        phase_n = 0;
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: write_regs(16'hFFFF, 16'hFFFF, -16'sd16384, 16'sd0, 16'sd0);
                1: write_regs(16'h0000, 16'h0000, 16'sd0, 16'sd0, 16'sd0);
                2: write_regs(16'd640, 16'd6554, 16'sd0, 16'sd16384, 16'sd0);
                3: write_regs(16'h8000, 16'hFFFF, 16'sd0, -16'sd16384, 16'sd16384);
                default: write_regs($urandom, $urandom,
                                    $urandom_range(0, 32768) - 16384,
                                    $urandom_range(0, 32768) - 16384,
                                    $urandom_range(0, 32768) - 16384);
            endcase
            case (ph % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 81; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 81; end
                default: begin tx_idle_pct = 27; rx_stall_pct = 27; end
            endcase
            for (int n = 0; n < 60; n++)
            begin
                // one long receiver hold while items keep coming, so the block backs up
                if (ph == 4 && n == 10)
                    hold_request = 1;
                // once, stop sending until every pose is back
                if (ph == 5 && n == 30)
                    drain_poses();
                send_item(rand_item());
            end
            drain_poses();
            phase_n++;
        end

        $display("%0d items in %0d register settings, %0d poses checked, %0d mismatching",
                 items_sent, phase_n + 1, poses_seen, mismatches);
        $display("covered moves, looks, pose loads, reports, saturation and degenerate vectors");
        if (mismatches == 0 && pose_q.size() == 0)
            $display("PASS euler_fly_camera_update");
        else
            $display("FAIL euler_fly_camera_update");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("FAIL euler_fly_camera_update");
        $finish;
    end

endmodule

### filelist.f
src/ecam_pkg.sv
src/ecam_ctrl.sv
src/ecam_dp.sv
src/euler_fly_camera_update.sv
tb/sv/euler_fly_camera_update_tb.sv
